// ===== hw/rtl/pa3d_pkg.sv =====
// Shared types, widths, status codes and cross-product helpers for the 3D polygon area block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pa3d_pkg;

    localparam int COORD_W = 12;   // vertex coordinate
    localparam int DIFF_W  = 13;   // difference of two coordinates
    localparam int TERM_W  = 25;   // one cross-product component of two vertices
    localparam int NORM_W  = 27;   // normal component
    localparam int PLANE_W = 42;   // normal dotted with a vertex offset
    localparam int SUM_W   = 38;   // running cross-product sum, room for 4097 terms
    localparam int TOL_W   = 40;
    localparam int AREA_W  = 33;
    localparam int STAT_W  = 3;

    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_FEW         = 3'd1;
    localparam logic [STAT_W-1:0] ST_NONPLANAR   = 3'd2;
    localparam logic [STAT_W-1:0] ST_ZERO_NORMAL = 3'd3;
    localparam logic [STAT_W-1:0] ST_TOO_MANY    = 3'd4;

    localparam logic [AREA_W-1:0] AREA_MAX = '1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [TERM_W-1:0]  term_t;
    typedef logic signed [NORM_W-1:0]  norm_t;
    typedef logic signed [PLANE_W-1:0] plane_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    typedef struct packed {
        coord_t vertex_x;
        coord_t vertex_y;
        coord_t vertex_z;
        logic   last_vertex;
    } vertex_t;

    typedef struct packed {
        logic [AREA_W-1:0] area_q8;
        logic [STAT_W-1:0] status;
    } result_t;

    // One finished polygon handed from the front to the back; index 0 is x
    typedef struct packed {
        logic [STAT_W-1:0] status;
        sum_t   [2:0]      sum;
        norm_t  [2:0]      norm;
        coord_t [2:0]      last_v;
        coord_t [2:0]      first_v;
    } job_t;

    // a*b - c*d on raw coordinates
    function automatic term_t vtx_cross(coord_t a, coord_t b, coord_t c, coord_t d);
        return term_t'(a) * term_t'(b) - term_t'(c) * term_t'(d);
    endfunction

    // a*b - c*d on coordinate differences
    function automatic norm_t diff_cross(diff_t a, diff_t b, diff_t c, diff_t d);
        return norm_t'(a) * norm_t'(b) - norm_t'(c) * norm_t'(d);
    endfunction

endpackage

// ===== hw/rtl/pa3d_front.sv =====
// Front end: accepts vertices, keeps the per-polygon state, forms the normal, the
// coplanarity test and the running cross-product sum, and issues one job per polygon.
// Depends on pa3d_pkg.
`timescale 1ns / 1ps

module pa3d_front #(
    parameter int MAX_VERTICES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pa3d_pkg::vertex_t  vertex,
    input  logic               vertex_valid,
    output logic               vertex_ready,
    input  logic [pa3d_pkg::TOL_W-1:0] plane_tolerance,
    output pa3d_pkg::job_t     job,
    output logic               job_valid,
    input  logic               job_ready
);
    import pa3d_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 2);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_VERTICES);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);

    // role of a vertex inside its polygon
    localparam logic [2:0] K_FIRST  = 3'd0;
    localparam logic [2:0] K_SECOND = 3'd1;
    localparam logic [2:0] K_THIRD  = 3'd2;
    localparam logic [2:0] K_LATER  = 3'd3;
    localparam logic [2:0] K_SKIP   = 3'd4;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    coord_t [2:0]     first_reg, second_reg, prev_reg, v_in;
    logic [2:0]       kind_in;

    logic             a_valid_reg, a_last_reg;
    logic [2:0]       a_kind_reg;
    logic [CNT_W-1:0] a_cnt_reg;
    coord_t [2:0]     a_vtx_reg, a_prev_reg, a_first_reg;
    diff_t  [2:0]     a_diff_reg, a_s1_reg, a_s2_reg;

    norm_t [2:0]      normal_reg, normal_next, normal_new;
    sum_t  [2:0]      sum_reg, sum_next;
    logic             planar_reg, planar_next;
    term_t [2:0]      term;
    plane_t           plane_dot;
    logic [PLANE_W-1:0] plane_abs;
    logic             take, adv;

    assign v_in = {vertex.vertex_z, vertex.vertex_y, vertex.vertex_x};
    assign adv          = a_valid_reg && (!a_last_reg || job_ready);
    assign vertex_ready = !a_valid_reg || adv;
    assign take         = vertex_valid && vertex_ready;
    assign job_valid    = a_valid_reg && a_last_reg;

    // classify the incoming vertex by its position in the polygon
    always_comb
    begin
        priority if (cnt_reg >= CNT_MAX) kind_in = K_SKIP;
        else if (cnt_reg == '0)          kind_in = K_FIRST;
        else if (cnt_reg == CNT_ONE)     kind_in = K_SECOND;
        else if (cnt_reg == CNT_TWO)     kind_in = K_THIRD;
        else                             kind_in = K_LATER;
        cnt_next = (cnt_reg <= CNT_MAX) ? cnt_reg + CNT_ONE : cnt_reg;
    end

    // hold the raw vertex state; drop it all once the last vertex is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_last_reg  <= 1'b0;
            cnt_reg     <= '0;
            first_reg   <= '0;
            second_reg  <= '0;
            prev_reg    <= '0;
        end
        else
        begin
            if (take)
            begin
                a_valid_reg <= 1'b1;
                a_last_reg  <= vertex.last_vertex;
                if (vertex.last_vertex)
                begin
                    cnt_reg    <= '0;
                    first_reg  <= '0;
                    second_reg <= '0;
                    prev_reg   <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_next;
                    if (kind_in == K_FIRST)  first_reg  <= v_in;
                    if (kind_in == K_SECOND) second_reg <= v_in;
                    if (kind_in != K_SKIP)   prev_reg   <= v_in;
                end
            end
            else if (adv)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    // capture operands for the product stage
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_kind_reg  <= kind_in;
            a_cnt_reg   <= cnt_next;
            a_vtx_reg   <= v_in;
            a_prev_reg  <= prev_reg;
            a_first_reg <= (kind_in == K_FIRST) ? v_in : first_reg;
            for (int i = 0; i < 3; i++)
            begin
                a_diff_reg[i] <= diff_t'(v_in[i]) - diff_t'(first_reg[i]);
                a_s1_reg[i]   <= diff_t'(second_reg[i]) - diff_t'(first_reg[i]);
                a_s2_reg[i]   <= diff_t'(second_reg[i]) - diff_t'(v_in[i]);
            end
        end
    end

    // cross product with the previous vertex, candidate normal, plane distance
    always_comb
    begin
        term[0] = vtx_cross(a_prev_reg[1], a_vtx_reg[2], a_prev_reg[2], a_vtx_reg[1]);
        term[1] = vtx_cross(a_prev_reg[2], a_vtx_reg[0], a_prev_reg[0], a_vtx_reg[2]);
        term[2] = vtx_cross(a_prev_reg[0], a_vtx_reg[1], a_prev_reg[1], a_vtx_reg[0]);
        normal_new[0] = diff_cross(a_s1_reg[1], a_s2_reg[2], a_s1_reg[2], a_s2_reg[1]);
        normal_new[1] = diff_cross(a_s1_reg[2], a_s2_reg[0], a_s1_reg[0], a_s2_reg[2]);
        normal_new[2] = diff_cross(a_s1_reg[0], a_s2_reg[1], a_s1_reg[1], a_s2_reg[0]);
        plane_dot = plane_t'(normal_reg[0]) * plane_t'(a_diff_reg[0])
                  + plane_t'(normal_reg[1]) * plane_t'(a_diff_reg[1])
                  + plane_t'(normal_reg[2]) * plane_t'(a_diff_reg[2]);
        plane_abs = plane_dot[PLANE_W-1] ? PLANE_W'(-plane_dot) : PLANE_W'(plane_dot);
    end

    // update the polygon accumulators
    always_comb
    begin
        normal_next = normal_reg;
        sum_next    = sum_reg;
        planar_next = planar_reg;
        unique case (a_kind_reg)
            K_FIRST, K_SKIP: ;
            K_SECOND:
            begin
                for (int i = 0; i < 3; i++) sum_next[i] = sum_reg[i] + sum_t'(term[i]);
            end
            K_THIRD:
            begin
                normal_next = normal_new;
                for (int i = 0; i < 3; i++) sum_next[i] = sum_reg[i] + sum_t'(term[i]);
            end
            K_LATER:
            begin
                if (plane_abs > PLANE_W'(plane_tolerance)) planar_next = 1'b0;
                for (int i = 0; i < 3; i++) sum_next[i] = sum_reg[i] + sum_t'(term[i]);
            end
            default: ;
        endcase
    end

    // job for the back end, errors settled here where they are known
    always_comb
    begin
        priority if (a_cnt_reg < CNT_THREE) job.status = ST_FEW;
        else if (a_cnt_reg > CNT_MAX)       job.status = ST_TOO_MANY;
        else if (!planar_next)              job.status = ST_NONPLANAR;
        else                                job.status = ST_OK;
        job.sum     = sum_next;
        job.norm    = normal_next;
        job.last_v  = a_vtx_reg;
        job.first_v = a_first_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg <= '0;
            sum_reg    <= '0;
            planar_reg <= 1'b1;
        end
        else if (adv)
        begin
            if (a_last_reg)
            begin
                normal_reg <= '0;
                sum_reg    <= '0;
                planar_reg <= 1'b1;
            end
            else
            begin
                normal_reg <= normal_next;
                sum_reg    <= sum_next;
                planar_reg <= planar_next;
            end
        end
    end

endmodule

// ===== hw/rtl/pa3d_queue.sv =====
// Two-entry job queue between the front and back ends of the polygon area block.
// Depends on pa3d_pkg.
`timescale 1ns / 1ps

module pa3d_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  pa3d_pkg::job_t push_job,
    input  logic           push_valid,
    output logic           push_ready,
    output pa3d_pkg::job_t pop_job,
    output logic           pop_valid,
    input  logic           pop_ready
);
    import pa3d_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // store a transfer
    always_ff @(posedge clk)
    begin
        if (push) entry_reg[wr_ptr_reg] <= push_job;
    end

    // advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && count_reg == 2'd2))
        else $error("job queue written while full");

endmodule

// ===== hw/rtl/pa3d_back.sv =====
// Back end: closes the polygon, forms S.n and |n|^2 on one shared multiplier, then
// area = floor(sqrt(floor(65536*S.n^2 / (4*|n|^2)))) by serial square, divide and root.
// Depends on pa3d_pkg.
`timescale 1ns / 1ps

module pa3d_back (
    input  logic              clk,
    input  logic              rst_n,
    input  pa3d_pkg::job_t    job,
    input  logic              job_valid,
    output logic              job_ready,
    output pa3d_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_ready
);
    import pa3d_pkg::*;

    localparam int PROD_W = SUM_W + NORM_W;
    localparam int DOT_W  = SUM_W + NORM_W + 2;
    localparam int NN_W   = 2 * NORM_W + 2;
    localparam int MAG_W  = 56;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int R_W    = SQ_W + 14;
    localparam int Q_W    = 2 * AREA_W;
    localparam int RR_W   = AREA_W + 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SQ    = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_ROOT  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // multiply steps: closing term, then S.n, then |n|^2
    localparam logic [3:0] M_SX_P  = 4'd0;
    localparam logic [3:0] M_SX_N  = 4'd1;
    localparam logic [3:0] M_SY_P  = 4'd2;
    localparam logic [3:0] M_SY_N  = 4'd3;
    localparam logic [3:0] M_SZ_P  = 4'd4;
    localparam logic [3:0] M_SZ_N  = 4'd5;
    localparam logic [3:0] M_DOT_X = 4'd6;
    localparam logic [3:0] M_DOT_Y = 4'd7;
    localparam logic [3:0] M_DOT_Z = 4'd8;
    localparam logic [3:0] M_NN_X  = 4'd9;
    localparam logic [3:0] M_NN_Y  = 4'd10;
    localparam logic [3:0] M_NN_Z  = 4'd11;
    localparam logic [3:0] M_FLUSH = 4'd12;

    localparam logic [6:0] SQ_LAST   = 7'(MAG_W - 1);
    localparam logic [6:0] DIV_LAST  = 7'(R_W - 1);
    localparam logic [6:0] ROOT_LAST = 7'(AREA_W - 1);

    logic [2:0]  state_reg, state_next;
    logic [3:0]  step_reg, step_next, tag_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        pv_reg, pv_next;
    logic        out_valid_reg;
    result_t     out_reg, res_reg;
    job_t        job_reg;

    sum_t  [2:0]         acc_reg;
    logic signed [DOT_W-1:0] dot_reg;
    logic [NN_W-1:0]     nn_reg;
    sum_t                mul_a;
    norm_t               mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic [DOT_W-1:0]    dot_abs;
    logic                too_big;

    logic [MAG_W-1:0]    mag_reg;
    logic [SQ_W-1:0]     sq_reg, mcand_reg, sq_add;
    logic [R_W-1:0]      div_reg;
    logic [NN_W-1:0]     rem_reg;
    logic [NN_W:0]       rem_sh, rem_new;
    logic                q_bit;
    logic [Q_W-1:0]      quo_reg, quo_new;
    logic                ovf_reg, ovf_new;
    logic [Q_W-1:0]      rad_reg;
    logic [AREA_W-1:0]   root_reg, root_new;
    logic [RR_W-1:0]     rrem_reg;
    logic [RR_W+1:0]     rrem_sh, trial;
    logic                r_bit;
    logic                out_free;

    assign job_ready    = (state_reg == S_IDLE);
    assign result       = out_reg;
    assign result_valid = out_valid_reg;
    assign out_free     = !out_valid_reg || result_ready;

    // shared multiplier operand select
    always_comb
    begin
        unique case (step_reg)
            M_SX_P:  begin mul_a = sum_t'(job_reg.last_v[1]); mul_b = norm_t'(job_reg.first_v[2]); end
            M_SX_N:  begin mul_a = sum_t'(job_reg.last_v[2]); mul_b = norm_t'(job_reg.first_v[1]); end
            M_SY_P:  begin mul_a = sum_t'(job_reg.last_v[2]); mul_b = norm_t'(job_reg.first_v[0]); end
            M_SY_N:  begin mul_a = sum_t'(job_reg.last_v[0]); mul_b = norm_t'(job_reg.first_v[2]); end
            M_SZ_P:  begin mul_a = sum_t'(job_reg.last_v[0]); mul_b = norm_t'(job_reg.first_v[1]); end
            M_SZ_N:  begin mul_a = sum_t'(job_reg.last_v[1]); mul_b = norm_t'(job_reg.first_v[0]); end
            M_DOT_X: begin mul_a = acc_reg[0]; mul_b = job_reg.norm[0]; end
            M_DOT_Y: begin mul_a = acc_reg[1]; mul_b = job_reg.norm[1]; end
            M_DOT_Z: begin mul_a = acc_reg[2]; mul_b = job_reg.norm[2]; end
            M_NN_X:  begin mul_a = sum_t'(job_reg.norm[0]); mul_b = job_reg.norm[0]; end
            M_NN_Y:  begin mul_a = sum_t'(job_reg.norm[1]); mul_b = job_reg.norm[1]; end
            M_NN_Z:  begin mul_a = sum_t'(job_reg.norm[2]); mul_b = job_reg.norm[2]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // magnitude of S.n and the serial square, divide and root steps
    always_comb
    begin
        dot_abs = dot_reg[DOT_W-1] ? DOT_W'(-dot_reg) : DOT_W'(dot_reg);
        too_big = (dot_abs[DOT_W-1:MAG_W] != '0);
        sq_add  = mag_reg[0] ? sq_reg + mcand_reg : sq_reg;

        rem_sh  = {rem_reg, div_reg[R_W-1]};
        q_bit   = (rem_sh >= {1'b0, nn_reg});
        rem_new = q_bit ? rem_sh - {1'b0, nn_reg} : rem_sh;
        quo_new = {quo_reg[Q_W-2:0], q_bit};
        ovf_new = ovf_reg | quo_reg[Q_W-1];

        rrem_sh  = {rrem_reg, rad_reg[Q_W-1:Q_W-2]};
        trial    = {2'b00, root_reg, 2'b01};
        r_bit    = (rrem_sh >= trial);
        root_new = {root_reg[AREA_W-2:0], r_bit};
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        pv_next    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                step_next = M_SX_P;
                if (job_valid) state_next = (job.status == ST_OK) ? S_MAC : S_DONE;
            end
            S_MAC:
            begin
                if (step_reg == M_FLUSH)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    pv_next   = 1'b1;
                    step_next = step_reg + 4'd1;
                end
            end
            S_CHECK:
            begin
                cnt_next   = '0;
                state_next = (nn_reg == '0 || too_big) ? S_DONE : S_SQ;
            end
            S_SQ:
            begin
                cnt_next = (cnt_reg == SQ_LAST) ? '0 : cnt_reg + 7'd1;
                if (cnt_reg == SQ_LAST) state_next = S_DIV;
            end
            S_DIV:
            begin
                cnt_next = (cnt_reg == DIV_LAST) ? '0 : cnt_reg + 7'd1;
                if (cnt_reg == DIV_LAST) state_next = ovf_new ? S_DONE : S_ROOT;
            end
            S_ROOT:
            begin
                cnt_next = (cnt_reg == ROOT_LAST) ? '0 : cnt_reg + 7'd1;
                if (cnt_reg == ROOT_LAST) state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= M_SX_P;
            cnt_reg       <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
            pv_reg    <= pv_next;
            if (state_reg == S_DONE && out_free) out_valid_reg <= 1'b1;
            else if (result_ready)               out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        tag_reg  <= step_reg;
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_reg <= job;
                    acc_reg <= job.sum;
                    dot_reg <= '0;
                    nn_reg  <= '0;
                    res_reg <= '{area_q8: '0, status: job.status};
                end
            end
            S_MAC:
            begin
                if (pv_reg)
                begin
                    unique case (tag_reg)
                        M_SX_P: acc_reg[0] <= acc_reg[0] + sum_t'(prod_reg);
                        M_SX_N: acc_reg[0] <= acc_reg[0] - sum_t'(prod_reg);
                        M_SY_P: acc_reg[1] <= acc_reg[1] + sum_t'(prod_reg);
                        M_SY_N: acc_reg[1] <= acc_reg[1] - sum_t'(prod_reg);
                        M_SZ_P: acc_reg[2] <= acc_reg[2] + sum_t'(prod_reg);
                        M_SZ_N: acc_reg[2] <= acc_reg[2] - sum_t'(prod_reg);
                        M_DOT_X, M_DOT_Y, M_DOT_Z: dot_reg <= dot_reg + DOT_W'(prod_reg);
                        M_NN_X, M_NN_Y, M_NN_Z:    nn_reg  <= nn_reg + NN_W'(prod_reg);
                        default: ;
                    endcase
                end
            end
            S_CHECK:
            begin
                if (nn_reg == '0)
                    res_reg <= '{area_q8: '0, status: ST_ZERO_NORMAL};
                else if (too_big)
                    res_reg <= '{area_q8: AREA_MAX, status: ST_OK};
                mag_reg   <= dot_abs[MAG_W-1:0];
                mcand_reg <= SQ_W'(dot_abs[MAG_W-1:0]);
                sq_reg    <= '0;
            end
            S_SQ:
            begin
                sq_reg    <= sq_add;
                mcand_reg <= mcand_reg << 1;
                mag_reg   <= mag_reg >> 1;
                div_reg   <= {sq_add, 14'b0};
                rem_reg   <= '0;
                quo_reg   <= '0;
                ovf_reg   <= 1'b0;
            end
            S_DIV:
            begin
                div_reg  <= div_reg << 1;
                rem_reg  <= rem_new[NN_W-1:0];
                quo_reg  <= quo_new;
                ovf_reg  <= ovf_new;
                rad_reg  <= quo_new;
                root_reg <= '0;
                rrem_reg <= '0;
                res_reg  <= '{area_q8: AREA_MAX, status: ST_OK};
            end
            S_ROOT:
            begin
                rad_reg  <= rad_reg << 2;
                root_reg <= root_new;
                rrem_reg <= r_bit ? RR_W'(rrem_sh - trial) : RR_W'(rrem_sh);
                res_reg  <= '{area_q8: root_new, status: ST_OK};
            end
            S_DONE:
            begin
                if (out_free) out_reg <= res_reg;
            end
            default: ;
        endcase
    end

    a_err_zero_area: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.status == ST_OK || out_reg.area_q8 == '0))
        else $error("error status with non-zero area");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < nn_reg))
        else $error("division remainder not below divisor");

    a_root_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROOT) |-> !ovf_reg)
        else $error("square root entered with quotient overflow");

endmodule

// ===== hw/rtl/polygon_area_3d_unit.sv =====
// Top level of the 3D polygon area block: front end, job queue, back end and the
// plane tolerance register. Depends on pa3d_pkg, pa3d_front, pa3d_queue, pa3d_back.
//
// Use:
//   vertex / vertex_valid / vertex_ready carry one vertex per transfer; last_vertex
//   closes the polygon. result / result_valid / result_ready carry one area and
//   status per polygon. plane_tolerance_we writes plane_tolerance_wdata at once.
//   Vertices are taken one per cycle while vertex_ready is high. The front end
//   registers each vertex, then the polygon waits in a two-entry queue. For a
//   valid polygon the back end runs 13 multiply-accumulate steps on its one
//   multiplier, then 56 square, 126 divide and 33 root steps, one bit per
//   cycle, and skips them for an error status; one polygon at a time sets the rate.
//   Reset clears the tolerance and all polygon state and empties the queue.
//   A stalled receiver holds the result register; the back end then waits,
//   the queue fills, and vertex_ready drops once the front end holds a finished
//   polygon it cannot hand on.
`timescale 1ns / 1ps

module polygon_area_3d_unit #(
    parameter int MAX_VERTICES = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pa3d_pkg::vertex_t           vertex,
    input  logic                        vertex_valid,
    output logic                        vertex_ready,
    output pa3d_pkg::result_t           result,
    output logic                        result_valid,
    input  logic                        result_ready,
    input  logic                        plane_tolerance_we,
    input  logic [pa3d_pkg::TOL_W-1:0]  plane_tolerance_wdata
);
    import pa3d_pkg::*;

    logic [TOL_W-1:0] tol_reg;
    job_t             f_job, q_job;
    logic             f_valid, f_ready, q_valid, q_ready;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)                  tol_reg <= '0;
        else if (plane_tolerance_we) tol_reg <= plane_tolerance_wdata;
    end

    pa3d_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .vertex          (vertex),
        .vertex_valid    (vertex_valid),
        .vertex_ready    (vertex_ready),
        .plane_tolerance (tol_reg),
        .job             (f_job),
        .job_valid       (f_valid),
        .job_ready       (f_ready)
    );

    pa3d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (f_job),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .pop_job    (q_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready)
    );

    pa3d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (q_job),
        .job_valid    (q_valid),
        .job_ready    (q_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule
